FILE: sv/vrp_pkg.sv
// package: sine rom, angle reduction and shared types for vertex_rotate_project
`timescale 1ns / 1ps
package vrp_pkg;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 15;

    localparam logic [CfgIdxW-1:0] CfgAngleX = 3'd0;
    localparam logic [CfgIdxW-1:0] CfgAngleY = 3'd1;
    localparam logic [CfgIdxW-1:0] CfgAngleZ = 3'd2;
    localparam logic [CfgIdxW-1:0] CfgCenterX = 3'd3;
    localparam logic [CfgIdxW-1:0] CfgCenterY = 3'd4;
    localparam logic [CfgIdxW-1:0] CfgCamDist = 3'd5;
    localparam logic [CfgIdxW-1:0] CfgFocal = 3'd6;

    typedef logic [16:0] t_rom_word;
    typedef logic [8:0] t_degree;

    localparam t_rom_word QUARTER_SINE [0:90] = '{
        17'd0, 17'd1144, 17'd2287, 17'd3430, 17'd4572, 17'd5712, 17'd6850,
        17'd7987, 17'd9121, 17'd10252, 17'd11380, 17'd12505, 17'd13626,
        17'd14742, 17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252,
        17'd21336, 17'd22415, 17'd23486, 17'd24550, 17'd25607, 17'd26656,
        17'd27697, 17'd28729, 17'd29753, 17'd30767, 17'd31772, 17'd32768,
        17'd33754, 17'd34729, 17'd35693, 17'd36647, 17'd37590, 17'd38521,
        17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995, 17'd43852,
        17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
        17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020,
        17'd53684, 17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756,
        17'd57319, 17'd57865, 17'd58393, 17'd58903, 17'd59396, 17'd59870,
        17'd60326, 17'd60764, 17'd61183, 17'd61584, 17'd61966, 17'd62328,
        17'd62672, 17'd62997, 17'd63303, 17'd63589, 17'd63856, 17'd64104,
        17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65048, 17'd65177,
        17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
    };

    // signed 11 bit angle to 0..359
    function automatic t_degree reduce_angle(input logic [10:0] a);
        logic [11:0] t;
        t = 12'($signed({a[10], a}) + 13'sd1080);
        if (t >= 12'd1440) t = t - 12'd1440;
        if (t >= 12'd720) t = t - 12'd720;
        if (t >= 12'd360) t = t - 12'd360;
        return t[8:0];
    endfunction

    function automatic t_degree add_quarter(input t_degree d);
        logic [9:0] t;
        t = {1'b0, d} + 10'd90;
        if (t >= 10'd360) t = t - 10'd360;
        return t[8:0];
    endfunction

endpackage

FILE: sv/vrp_divider.sv
// pipelined restoring divider: signed dividend by positive divisor, truncating
`timescale 1ns / 1ps
module vrp_divider #(
    parameter int DEN_W = 15
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic signed [31:0] i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic signed [31:0] o_quo
);

    logic [DEN_W-1:0] r_rem [0:31];
    logic [31:0]      r_work [0:31];
    logic [DEN_W-1:0] r_den [0:31];
    logic             r_neg [0:31];

    genvar k;
    generate
        for (k = 0; k < 32; k++) begin : g_step
            logic [DEN_W-1:0] rem_in;
            logic [31:0]      work_in;
            logic [DEN_W-1:0] den_in;
            logic             neg_in;
            logic [DEN_W:0]   sh;
            logic             ge;
            if (k == 0) begin : g_first
                assign rem_in = '0;
                assign work_in = i_num[31] ? 32'(-i_num) : i_num;
                assign den_in = i_den;
                assign neg_in = i_num[31];
            end else begin : g_rest
                assign rem_in = r_rem[k-1];
                assign work_in = r_work[k-1];
                assign den_in = r_den[k-1];
                assign neg_in = r_neg[k-1];
            end
            assign sh = {rem_in, work_in[31]};
            assign ge = sh >= {1'b0, den_in};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? DEN_W'(sh - {1'b0, den_in}) : sh[DEN_W-1:0];
                    r_work[k] <= {work_in[30:0], ge};
                    r_den[k] <= den_in;
                    r_neg[k] <= neg_in;
                end
            end
        end
    endgenerate

    assign o_quo = r_neg[31] ? 32'(-r_work[31]) : r_work[31];

endmodule

FILE: sv/vertex_rotate_project.sv
// top level: euler rotation and perspective projection of a vertex stream
// usage:
//   input channel i_valid / o_ready carries one vertex item (16.16 fixed point)
//   output channel o_valid / i_ready carries one screen point item per vertex
//   configuration: i_cfg_we with i_cfg_idx and i_cfg_data, written while idle
//   angles are reduced and turned into sine / cosine when written
// pipeline from acceptance to o_valid:
//   seven stages of rotation multiply / add and projection multiply,
//   32 stages of the restoring divider (one quotient bit per stage),
//   one stage that adds the screen centre
// throughput: one item per cycle while the output is not stalled; each divider stage resolves one bit
// reset: the valid bits clear and the registers return to angles 0,
//   centre 320 / 240, camera distance 300, focal length 256
// stall: when an item waits at the output and i_ready is low the whole
//   pipeline holds and o_ready drops; nothing is lost or repeated
`timescale 1ns / 1ps
module vertex_rotate_project #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [31:0]           i_vertex_x,
    input  logic signed [31:0]           i_vertex_y,
    input  logic signed [31:0]           i_vertex_z,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [31:0]           o_screen_x,
    output logic signed [31:0]           o_screen_y,
    input  logic                         i_cfg_we,
    input  logic [vrp_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [vrp_pkg::CfgDataW-1:0] i_cfg_data
);

    localparam int F = FRACTION_BITS;
    localparam int DEN_W = 31 - F;
    localparam int UP = (F >= 16) ? F - 16 : 0;
    localparam int DN = (F < 16) ? 16 - F : 1;
    localparam int LAT = 40;
    localparam logic [31:0] ONE = 32'd1 << F;

    function automatic logic [31:0] rom_scaled(input vrp_pkg::t_rom_word v);
        logic [31:0] w;
        w = {15'd0, v};
        if (F >= 16) return w << UP;
        return (w + (32'd1 << (DN - 1))) >> DN;
    endfunction

    function automatic logic [31:0] sine_of(input vrp_pkg::t_degree d);
        logic [31:0] r;
        if (d <= 9'd90) r = rom_scaled(vrp_pkg::QUARTER_SINE[d[6:0]]);
        else if (d <= 9'd180) r = rom_scaled(vrp_pkg::QUARTER_SINE[7'(9'd180 - d)]);
        else if (d <= 9'd270) r = -rom_scaled(vrp_pkg::QUARTER_SINE[7'(d - 9'd180)]);
        else r = -rom_scaled(vrp_pkg::QUARTER_SINE[7'(9'd360 - d)]);
        return r;
    endfunction

    function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
        logic signed [63:0] p;
        p = $signed(a) * $signed(b);
        return p[F+31:F];
    endfunction

    // configuration
    logic [31:0] r_sin_x, r_cos_x, r_sin_y, r_cos_y, r_sin_z, r_cos_z;
    logic [11:0] r_center_x, r_center_y;
    logic [14:0] r_cam, r_focal;
    vrp_pkg::t_degree n_deg;
    logic [31:0] n_sin, n_cos;

    always_comb begin
        n_deg = vrp_pkg::reduce_angle(i_cfg_data[10:0]);
        n_sin = sine_of(n_deg);
        n_cos = sine_of(vrp_pkg::add_quarter(n_deg));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_x <= '0;
            r_cos_x <= ONE;
            r_sin_y <= '0;
            r_cos_y <= ONE;
            r_sin_z <= '0;
            r_cos_z <= ONE;
            r_center_x <= 12'd320;
            r_center_y <= 12'd240;
            r_cam <= 15'd300;
            r_focal <= 15'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vrp_pkg::CfgAngleX: begin r_sin_x <= n_sin; r_cos_x <= n_cos; end
                vrp_pkg::CfgAngleY: begin r_sin_y <= n_sin; r_cos_y <= n_cos; end
                vrp_pkg::CfgAngleZ: begin r_sin_z <= n_sin; r_cos_z <= n_cos; end
                vrp_pkg::CfgCenterX: r_center_x <= i_cfg_data[11:0];
                vrp_pkg::CfgCenterY: r_center_y <= i_cfg_data[11:0];
                vrp_pkg::CfgCamDist: r_cam <= i_cfg_data;
                vrp_pkg::CfgFocal: r_focal <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [31:0] cam_fx, focal_fx;
    assign cam_fx = 32'({17'd0, r_cam} << F);
    assign focal_fx = 32'({17'd0, r_focal} << F);

    // pipeline control
    logic [LAT-1:0] r_vld;
    logic en;
    assign en = !r_vld[LAT-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // datapath
    logic [31:0] r_s1_x, r_s1_a, r_s1_b, r_s1_c, r_s1_d;
    logic [31:0] r_s2_x, r_s2_y, r_s2_z;
    logic [31:0] r_s3_y, r_s3_a, r_s3_b, r_s3_c, r_s3_d;
    logic [31:0] r_s4_x, r_s4_y, r_s4_z;
    logic [31:0] r_s5_z, r_s5_a, r_s5_b, r_s5_c, r_s5_d;
    logic [31:0] r_s6_x, r_s6_y, r_s6_z;
    logic [31:0] r_s7_nx, r_s7_ny;
    logic [DEN_W-1:0] r_s7_den;
    logic [31:0] n_depth;
    logic [31:0] r_out_x, r_out_y;
    logic signed [31:0] quo_x, quo_y;

    always_comb begin
        n_depth = r_s6_z + cam_fx;
        if ($signed(n_depth) < $signed(ONE)) n_depth = ONE;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_x <= i_vertex_x;
            r_s1_a <= fmul(r_cos_x, i_vertex_y);
            r_s1_b <= fmul(r_sin_x, i_vertex_z);
            r_s1_c <= fmul(r_sin_x, i_vertex_y);
            r_s1_d <= fmul(r_cos_x, i_vertex_z);
            r_s2_x <= r_s1_x;
            r_s2_y <= r_s1_a - r_s1_b;
            r_s2_z <= r_s1_c + r_s1_d;
            r_s3_y <= r_s2_y;
            r_s3_a <= fmul(r_cos_y, r_s2_x);
            r_s3_b <= fmul(r_sin_y, r_s2_z);
            r_s3_c <= fmul(r_sin_y, r_s2_x);
            r_s3_d <= fmul(r_cos_y, r_s2_z);
            r_s4_y <= r_s3_y;
            r_s4_x <= r_s3_a + r_s3_b;
            r_s4_z <= r_s3_d - r_s3_c;
            r_s5_z <= r_s4_z;
            r_s5_a <= fmul(r_cos_z, r_s4_x);
            r_s5_b <= fmul(r_sin_z, r_s4_y);
            r_s5_c <= fmul(r_sin_z, r_s4_x);
            r_s5_d <= fmul(r_cos_z, r_s4_y);
            r_s6_z <= r_s5_z;
            r_s6_x <= r_s5_a - r_s5_b;
            r_s6_y <= r_s5_c + r_s5_d;
            r_s7_nx <= fmul(r_s6_x, focal_fx);
            r_s7_ny <= fmul(r_s6_y, focal_fx);
            r_s7_den <= n_depth[30:F];
            r_out_x <= {20'd0, r_center_x} + quo_x;
            r_out_y <= {20'd0, r_center_y} + quo_y;
        end
    end

    vrp_divider #(.DEN_W(DEN_W)) u_div_x (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s7_nx),
        .i_den (r_s7_den),
        .o_quo (quo_x)
    );

    vrp_divider #(.DEN_W(DEN_W)) u_div_y (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (r_s7_ny),
        .i_den (r_s7_den),
        .o_quo (quo_y)
    );

    assign o_screen_x = r_out_x;
    assign o_screen_y = r_out_y;

endmodule
